// File: hw/rtl/rwfc_pkg.sv
// ---------------------------------------------------------------------------
// rwfc_pkg: shared types and constants of the repeated word filter
// Character classes, repeat modes and the result beat layout.
// ---------------------------------------------------------------------------
`default_nettype none

package rwfc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] rep_lvl_t;

  localparam mode_t MODE_KEEP_ALL = 2'd0;
  localparam mode_t MODE_KEEP_ONE = 2'd1;
  localparam mode_t MODE_DROP_ALL = 2'd2;

  localparam rep_lvl_t REP_NONE = 2'd0;
  localparam rep_lvl_t REP_SAT  = 2'd2;

  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CASE_BIT   = 8'h20;

  typedef struct packed {
    char_t ch;
    logic  ch_valid;
    logic  done;
    logic  last;
    logic  trunc;
  } out_beat_t;

  function automatic logic rwfc_is_delim(input char_t b);
    rwfc_is_delim = b inside {[8'h09:8'h0D], [8'h20:8'h2F], [8'h3A:8'h40],
                              [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

  function automatic logic rwfc_is_upper(input char_t b);
    rwfc_is_upper = b inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic rwfc_is_lower(input char_t b);
    rwfc_is_lower = b inside {[8'h61:8'h7A]};
  endfunction

  function automatic char_t rwfc_fold(input char_t b);
    rwfc_fold = rwfc_is_upper(b) ? (b | CASE_BIT) : b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rwfc_word_mem.sv
// ---------------------------------------------------------------------------
// rwfc_word_mem: word store
// One write port, one read port, registered read data held while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module rwfc_word_mem #(
  parameter int ADDR_W = 6
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire  [ADDR_W-1:0]   waddr,
  input  rwfc_pkg::char_t     wdata,
  input  wire                 re,
  input  wire  [ADDR_W-1:0]   raddr,
  output rwfc_pkg::char_t     rdata
);
  import rwfc_pkg::*;

  char_t word_mem [2**ADDR_W];
  char_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      word_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= word_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/repeated_word_filter_capitalizer.sv
// ---------------------------------------------------------------------------
// repeated_word_filter_capitalizer: drop repeated words, capitalise the text
// Text enters one byte per in_ beat; kept words leave one byte per out_ beat.
// ---------------------------------------------------------------------------
// Usage:
//   in_ channel carries one text byte per beat, in_end_of_text on the last.
//   out_ channel carries the cleaned text, one byte per beat, words joined by
//   single spaces; out_last_of_run closes the beats of one input byte and
//   out_text_done the text. A text that yields nothing gives one marker beat
//   with out_byte_valid low. cfg_wr_en writes the repeat mode between texts.
// Timing:
//   Every input byte passes through S_IDLE, which writes/reads the word store,
//   and S_CMP, which compares with the previous word; a byte closing a text
//   with no kept word also passes through S_MARK for the marker. A kept word
//   streams from the registered store read at one beat a cycle while the
//   receiver is ready; the byte closing a word holds the input until it is out.
// Reset and stall:
//   Reset clears all control state; the store needs no clearing pass since
//   only entries below a written length are read. A stalled receiver holds
//   the output register and the burst waits; input is taken only between
//   bytes, never during a burst.
// ---------------------------------------------------------------------------
`default_nettype none

module repeated_word_filter_capitalizer #(
  parameter int MAX_WORD_LEN = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  rwfc_pkg::char_t  in_byte,
  input  wire              in_end_of_text,
  output logic             out_valid,
  input  wire              out_ready,
  output rwfc_pkg::char_t  out_byte,
  output logic             out_byte_valid,
  output logic             out_text_done,
  output logic             out_last_of_run,
  output logic             out_word_truncated,
  input  wire              cfg_wr_en,
  input  rwfc_pkg::mode_t  cfg_wr_data
);
  import rwfc_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EMIT, S_MARK} state_t;

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic       sel_r, sel_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0] prev_len_r, prev_len_nxt;
  logic       match_r, match_nxt;
  rep_lvl_t   rep_lvl_r, rep_lvl_nxt;
  logic       emitted_r, emitted_nxt;
  logic       cap_pend_r, cap_pend_nxt;
  logic       ovf_r, ovf_nxt;
  logic       eot_r, eot_nxt;
  logic       cmp_pend_r, cmp_pend_nxt;
  logic       space_pend_r, space_pend_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] emit_cnt_r, emit_cnt_nxt;

  char_t      byte_r, byte_nxt;
  logic       lt_prev_r, lt_prev_nxt;
  logic       emit_sel_r, emit_sel_nxt;
  logic [LEN_W-1:0] emit_len_r, emit_len_nxt;
  logic       emit_trunc_r, emit_trunc_nxt;
  logic       emit_eot_r, emit_eot_nxt;
  out_beat_t  out_r, out_nxt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  char_t             mem_rdata;

  logic     slot_free, room, sm_now, end_word, word_match, drop;
  logic     load_space, load_char, can_issue, last_char;
  rep_lvl_t lvl_inc;
  char_t    cap_char;

  rwfc_word_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (byte_nxt),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_byte           = out_r.ch;
  assign out_byte_valid     = out_r.ch_valid;
  assign out_text_done      = out_r.done;
  assign out_last_of_run    = out_r.last;
  assign out_word_truncated = out_r.trunc;

  assign slot_free  = !out_valid_r || out_ready;
  assign room       = cur_len_r < MAX_LEN;
  assign sm_now     = match_r && !(cmp_pend_r &&
                      !(lt_prev_r && rwfc_fold(mem_rdata) == rwfc_fold(byte_r)));
  assign end_word   = (rwfc_is_delim(byte_r) || eot_r) && (cur_len_r != '0);
  assign word_match = sm_now && (cur_len_r == prev_len_r);
  assign lvl_inc    = (rep_lvl_r == REP_SAT) ? REP_SAT : rep_lvl_r + 2'd1;
  assign drop       = word_match && ((mode_r >= MODE_DROP_ALL) ||
                      (mode_r == MODE_KEEP_ONE && lvl_inc == REP_SAT));
  assign load_space = (state_r == S_EMIT) && space_pend_r && slot_free;
  assign load_char  = (state_r == S_EMIT) && !space_pend_r && rd_pend_r && slot_free;
  assign can_issue  = (state_r == S_EMIT) && (emit_cnt_r != emit_len_r) &&
                      (!rd_pend_r || load_char);
  assign last_char  = emit_cnt_r == emit_len_r;
  assign cap_char   = (cap_pend_r && rwfc_is_lower(mem_rdata)) ?
                      (mem_rdata & ~CASE_BIT) : mem_rdata;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    sel_nxt        = sel_r;
    cur_len_nxt    = cur_len_r;
    prev_len_nxt   = prev_len_r;
    match_nxt      = match_r;
    rep_lvl_nxt    = rep_lvl_r;
    emitted_nxt    = emitted_r;
    cap_pend_nxt   = cap_pend_r;
    ovf_nxt        = ovf_r;
    eot_nxt        = eot_r;
    cmp_pend_nxt   = cmp_pend_r;
    space_pend_nxt = space_pend_r;
    rd_pend_nxt    = rd_pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    emit_cnt_nxt   = emit_cnt_r;
    byte_nxt       = byte_r;
    lt_prev_nxt    = lt_prev_r;
    emit_sel_nxt   = emit_sel_r;
    emit_len_nxt   = emit_len_r;
    emit_trunc_nxt = emit_trunc_r;
    emit_eot_nxt   = emit_eot_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = {sel_r, cur_len_r[IDX_W-1:0]};
    mem_raddr      = {~sel_r, cur_len_r[IDX_W-1:0]};

    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt     = in_byte;
          eot_nxt      = in_end_of_text;
          lt_prev_nxt  = cur_len_r < prev_len_r;
          cmp_pend_nxt = !rwfc_is_delim(in_byte) && room;
          if (!rwfc_is_delim(in_byte)) begin
            if (room) begin
              // write this byte, fetch the same place of the previous word
              mem_we      = 1'b1;
              mem_re      = 1'b1;
              cur_len_nxt = cur_len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        match_nxt = sm_now;
        state_nxt = eot_r ? S_MARK : S_IDLE;
        if (end_word) begin
          rep_lvl_nxt    = word_match ? lvl_inc : REP_NONE;
          cur_len_nxt    = '0;
          match_nxt      = 1'b1;
          ovf_nxt        = 1'b0;
          emit_len_nxt   = cur_len_r;
          emit_trunc_nxt = ovf_r;
          emit_sel_nxt   = sel_r;
          emit_eot_nxt   = eot_r;
          emit_cnt_nxt   = '0;
          rd_pend_nxt    = 1'b0;
          if (!drop) begin
            space_pend_nxt = emitted_r;
            emitted_nxt    = 1'b1;
            prev_len_nxt   = cur_len_r;
            sel_nxt        = ~sel_r;
            state_nxt      = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (can_issue) begin
          mem_re       = 1'b1;
          mem_raddr    = {emit_sel_r, emit_cnt_r[IDX_W-1:0]};
          emit_cnt_nxt = emit_cnt_r + 1'b1;
          rd_pend_nxt  = 1'b1;
        end else if (load_char) begin
          rd_pend_nxt = 1'b0;
        end
        if (load_space) begin
          out_nxt        = '{ch: CHAR_SPACE, ch_valid: 1'b1, done: 1'b0,
                             last: 1'b0, trunc: emit_trunc_r};
          out_valid_nxt  = 1'b1;
          space_pend_nxt = 1'b0;
        end
        if (load_char) begin
          if (rwfc_is_lower(mem_rdata) || rwfc_is_upper(mem_rdata)) begin
            cap_pend_nxt = 1'b0;
          end
          out_nxt       = '{ch: cap_char, ch_valid: 1'b1,
                            done: last_char && emit_eot_r,
                            last: last_char, trunc: emit_trunc_r};
          out_valid_nxt = 1'b1;
          if (last_char) begin
            state_nxt = S_IDLE;
            if (emit_eot_r) begin
              sel_nxt      = 1'b0;
              cur_len_nxt  = '0;
              prev_len_nxt = '0;
              match_nxt    = 1'b1;
              rep_lvl_nxt  = REP_NONE;
              emitted_nxt  = 1'b0;
              cap_pend_nxt = 1'b1;
              ovf_nxt      = 1'b0;
            end
          end
        end
      end
      S_MARK: begin
        if (slot_free) begin
          out_nxt       = '{ch: CHAR_NUL, ch_valid: 1'b0, done: 1'b1,
                            last: 1'b1, trunc: 1'b0};
          out_valid_nxt = 1'b1;
          sel_nxt       = 1'b0;
          cur_len_nxt   = '0;
          prev_len_nxt  = '0;
          match_nxt     = 1'b1;
          rep_lvl_nxt   = REP_NONE;
          emitted_nxt   = 1'b0;
          cap_pend_nxt  = 1'b1;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_KEEP_ALL;
      sel_r        <= 1'b0;
      cur_len_r    <= '0;
      prev_len_r   <= '0;
      match_r      <= 1'b1;
      rep_lvl_r    <= REP_NONE;
      emitted_r    <= 1'b0;
      cap_pend_r   <= 1'b1;
      ovf_r        <= 1'b0;
      eot_r        <= 1'b0;
      cmp_pend_r   <= 1'b0;
      space_pend_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      emit_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      sel_r        <= sel_nxt;
      cur_len_r    <= cur_len_nxt;
      prev_len_r   <= prev_len_nxt;
      match_r      <= match_nxt;
      rep_lvl_r    <= rep_lvl_nxt;
      emitted_r    <= emitted_nxt;
      cap_pend_r   <= cap_pend_nxt;
      ovf_r        <= ovf_nxt;
      eot_r        <= eot_nxt;
      cmp_pend_r   <= cmp_pend_nxt;
      space_pend_r <= space_pend_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
    end
    byte_r       <= byte_nxt;
    lt_prev_r    <= lt_prev_nxt;
    emit_sel_r   <= emit_sel_nxt;
    emit_len_r   <= emit_len_nxt;
    emit_trunc_r <= emit_trunc_nxt;
    emit_eot_r   <= emit_eot_nxt;
    out_r        <= out_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rwfc_checker.sv
// ---------------------------------------------------------------------------
// rwfc_checker: port-level checks of the repeated word filter
// Watches the channels of the top level over time; bound to it below.
// ---------------------------------------------------------------------------
`default_nettype none

module rwfc_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input rwfc_pkg::char_t out_byte,
  input wire             out_byte_valid,
  input wire             out_text_done,
  input wire             out_last_of_run,
  input wire             out_word_truncated
);
  import rwfc_pkg::*;

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled output beat changed");

  // every byte passes through the compare state before the next is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_last_of_run)
    else $error("text closed mid-run");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |->
      out_text_done && out_byte == CHAR_NUL && !out_word_truncated)
    else $error("malformed empty marker");

endmodule

bind repeated_word_filter_capitalizer rwfc_checker u_rwfc_checker (.*);

`default_nettype wire

// File: dv/tb_repeated_word_filter_capitalizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_repeated_word_filter_capitalizer: self-checking bench for the filter
// Feeds short texts of repeated, case-varied and over-long words under every
// repeat mode, predicts each output beat and checks it field by field.
// ---------------------------------------------------------------------------

module tb_repeated_word_filter_capitalizer;
  import rwfc_pkg::*;

  localparam int    WORD_MAX    = 32;
  localparam int    WORD_ROOM   = WORD_MAX + 8;
  localparam int    STALL_LIMIT = 4000;
  localparam int    SETTLE      = 40;
  localparam int    HOLD_CYCLES = 400;
  localparam int    PHASE_BYTES = 32;
  localparam mode_t MODE_ALIAS  = 2'd3;  // decodes as drop-all

  // Predicts the cleaned text and holds the beats still owed by the block
  class cleaned_text_board;
    mode_t     mode;
    char_t     word_buf [2][WORD_MAX];
    bit        sel;
    int        cur_len;
    int        prev_len;
    bit        still_same;
    bit        emitted;
    bit        cap_pending;
    bit        overflow;
    rep_lvl_t  rep;
    out_beat_t owed_beats [$];
    out_beat_t run [$];
    int        failures;

    function new();
      mode     = MODE_KEEP_ALL;
      failures = 0;
      clear_text();
    endfunction

    function void clear_text();
      sel         = 1'b0;
      cur_len     = 0;
      prev_len    = 0;
      still_same  = 1'b1;
      rep         = REP_NONE;
      emitted     = 1'b0;
      cap_pending = 1'b1;
      overflow    = 1'b0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function bit is_sep(char_t b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h21 && b <= 8'h2F) ||
             (b >= 8'h3A && b <= 8'h40) || (b >= 8'h5B && b <= 8'h60) ||
             (b >= 8'h7B && b <= 8'h7E);
    endfunction

    function char_t lower(char_t b);
      return (b >= 8'h41 && b <= 8'h5A) ? (b | CASE_BIT) : b;
    endfunction

    function void add_beat(char_t c, bit v, bit t);
      out_beat_t beat;
      if (v && cap_pending) begin
        if (c >= 8'h61 && c <= 8'h7A) begin
          c           = c & ~CASE_BIT;
          cap_pending = 1'b0;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
          cap_pending = 1'b0;
        end
      end
      beat.ch       = c;
      beat.ch_valid = v;
      beat.done     = 1'b0;
      beat.last     = 1'b0;
      beat.trunc    = t;
      run.insert(run.size(), beat);
    endfunction

    function void take_text_byte(char_t b, bit eot);
      bit sep;
      bit same_word;
      bit keep;
      int i;
      run.delete();
      sep = is_sep(b);
      if (!sep) begin
        if (cur_len < WORD_MAX) begin
          if (!(cur_len < prev_len && lower(word_buf[sel ^ 1'b1][cur_len]) == lower(b)))
            still_same = 1'b0;
          word_buf[sel][cur_len] = b;
          cur_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      if ((sep || eot) && cur_len > 0) begin
        same_word = still_same && (cur_len == prev_len);
        keep      = 1'b1;
        if (same_word) begin
          if (rep != REP_SAT) rep = rep + 1'b1;
          if ((mode >= MODE_DROP_ALL && rep != REP_NONE) ||
              (mode == MODE_KEEP_ONE && rep == REP_SAT))
            keep = 1'b0;
        end else begin
          rep = REP_NONE;
        end
        if (keep) begin
          if (emitted) add_beat(CHAR_SPACE, 1'b1, overflow);
          for (i = 0; i < cur_len; i++) add_beat(word_buf[sel][i], 1'b1, overflow);
          emitted  = 1'b1;
          prev_len = cur_len;
          sel      = sel ^ 1'b1;
        end
        cur_len    = 0;
        still_same = 1'b1;
        overflow   = 1'b0;
      end
      if (eot) begin
        // a text that yields nothing still closes with a marker beat
        if (run.size() == 0) add_beat(CHAR_NUL, 1'b0, 1'b0);
        run[run.size() - 1].done = 1'b1;
        clear_text();
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      for (i = 0; i < run.size(); i++) owed_beats.insert(owed_beats.size(), run[i]);
    endfunction

    function void match_out_beat(char_t ch, bit v, bit done, bit last, bit trunc);
      out_beat_t want;
      if (owed_beats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: ch=%02h valid=%b done=%b last=%b trunc=%b",
                   ch, v, done, last, trunc);
        return;
      end
      want = owed_beats.pop_front();
      if (ch !== want.ch || v !== want.ch_valid || done !== want.done ||
          last !== want.last || trunc !== want.trunc) begin
        failures++;
        if (failures <= 10)
          $display({"beat mismatch: exp ch=%02h v=%b done=%b last=%b trunc=%b, ",
                    "got ch=%02h v=%b done=%b last=%b trunc=%b"},
                   want.ch, want.ch_valid, want.done, want.last, want.trunc,
                   ch, v, done, last, trunc);
      end
    endfunction

    function int outstanding();
      return owed_beats.size();
    endfunction

    function void close();
      if (owed_beats.size() != 0) begin
        $display("%0d beats never arrived", owed_beats.size());
        failures += owed_beats.size();
      end
    endfunction
  endclass

  logic  clk            = 1'b0;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  char_t in_byte        = CHAR_NUL;
  logic  in_end_of_text = 1'b0;
  logic  out_ready      = 1'b0;
  logic  cfg_wr_en      = 1'b0;
  mode_t cfg_wr_data    = MODE_KEEP_ALL;
  wire   in_ready;
  wire   out_valid;
  char_t out_byte;
  wire   out_byte_valid;
  wire   out_text_done;
  wire   out_last_of_run;
  wire   out_word_truncated;

  cleaned_text_board sb;
  char_t text_q [$];
  char_t words [4][WORD_ROOM];
  int    word_len [4];
  logic  calm      = 1'b0;
  logic  hold_req  = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_left = 0;
  int    quiet_cycles = 0;
  mode_t phase_modes [8] = '{MODE_KEEP_ONE, MODE_ALIAS, MODE_KEEP_ALL, MODE_DROP_ALL,
                             MODE_KEEP_ONE, MODE_KEEP_ALL, MODE_ALIAS, MODE_DROP_ALL};

  repeated_word_filter_capitalizer #(
    .MAX_WORD_LEN(WORD_MAX)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_text_done      (out_text_done),
    .out_last_of_run    (out_last_of_run),
    .out_word_truncated (out_word_truncated),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output side: check each accepted beat, then choose next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.match_out_beat(out_byte, out_byte_valid, out_text_done, out_last_of_run,
                          out_word_truncated);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req && !hold_done) begin
        // starve the output so the block backs up onto its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("repeated_word_filter_capitalizer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input char_t b, input bit eot);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    sb.take_text_byte(b, eot);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) push_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_mode(input mode_t m);
    // let any burst still in flight drain before touching the register
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic void append_text_byte(input char_t b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic char_t word_char();
    char_t b;
    if ($urandom_range(99) < 75) return char_t'(8'h61 + $urandom_range(25));
    do b = char_t'($urandom_range(255)); while (sb.is_sep(b));
    return b;
  endfunction

  function automatic char_t sep_char();
    char_t b;
    if ($urandom_range(1) == 0) return CHAR_SPACE;
    do b = char_t'($urandom_range(255)); while (!sb.is_sep(b));
    return b;
  endfunction

  task automatic make_word(input int slot);
    int i;
    if ($urandom_range(11) == 0)
      word_len[slot] = $urandom_range(WORD_MAX - 1, WORD_ROOM);
    else
      word_len[slot] = $urandom_range(1, 6);
    for (i = 0; i < word_len[slot]; i++) words[slot][i] = word_char();
  endtask

  task automatic make_text();
    int    n_words;
    int    k;
    int    i;
    int    pick;
    int    src;
    char_t b;
    text_q.delete();
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 3)) append_text_byte(sep_char());
      return;
    end
    n_words = $urandom_range(1, 10);
    for (k = 0; k < n_words; k++) begin
      pick = $urandom_range(99);
      // slot 3 holds the word just sent; keep it to make a repeat
      if (k == 0 || pick >= 45) begin
        if (pick < 85) begin
          src         = $urandom_range(2);
          word_len[3] = word_len[src];
          for (i = 0; i < word_len[src]; i++) words[3][i] = words[src][i];
        end else begin
          make_word(3);
        end
      end
      for (i = 0; i < word_len[3]; i++) begin
        b = words[3][i];
        if (b >= 8'h61 && b <= 8'h7A && $urandom_range(99) < 20) b = b ^ CASE_BIT;
        append_text_byte(b);
      end
      if ($urandom_range(99) < 6) append_text_byte(char_t'($urandom_range(255)));
      if (k < n_words - 1 || $urandom_range(1) == 1)
        repeat ($urandom_range(1, 2)) append_text_byte(sep_char());
    end
  endtask

  initial begin : stimulus
    int ph;
    int phase_bytes;
    bit paused;
    sb     = new();
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_KEEP_ALL);
    // separators only: just the marker beat
    text_q = '{8'h20, 8'h2E};
    send_text();
    // leading digit delays the capital; NUL and high bytes form words
    text_q = '{"1", "a", 8'h20, "A", ",", "a", 8'h09, 8'hFF, 8'h00, "~", "z"};
    send_text();
    wait_results();
    write_mode(MODE_KEEP_ONE);
    text_q = '{"g", "o", " ", "G", "o", " ", "g", "O", "!"};
    send_text();
    wait_results();

    for (ph = 0; ph < 8; ph++) begin
      write_mode(phase_modes[ph]);
      calm <= (ph == 5);
      if (ph == 2) hold_req <= 1'b1;
      make_word(0);
      make_word(1);
      make_word(2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        make_text();
        send_text();
        phase_bytes += text_q.size();
        if (ph == 3 && !paused) begin
          paused = 1'b1;
          wait_results();
        end
      end
      wait_results();
    end
    calm <= 1'b0;

    repeat (SETTLE) @(posedge clk);
    sb.close();
    if (sb.failures == 0)
      $display("repeated_word_filter_capitalizer test passed");
    else
      $display("repeated_word_filter_capitalizer test failed");
    $finish;
  end

endmodule

// File: repeated_word_filter_capitalizer.f
hw/rtl/rwfc_pkg.sv
hw/rtl/rwfc_word_mem.sv
hw/rtl/repeated_word_filter_capitalizer.sv
hw/rtl/rwfc_checker.sv
dv/tb_repeated_word_filter_capitalizer.sv
